// File: design/dq_pkg.sv
`timescale 1ns / 1ps

package dq_pkg;

    typedef enum logic [1:0] {
        REQ_PUSH_FRONT = 2'd0,
        REQ_PUSH_BACK  = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } req_type_t;

    typedef enum logic [1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        req_type_t          req_type;
        logic signed [31:0] value;
    } req_t;

    typedef struct packed {
        logic signed [31:0] front_value;
        logic signed [31:0] back_value;
        logic [8:0]         element_count;
        logic               is_empty;
        status_t            status;
    } result_t;

    typedef struct packed {
        logic shift_up;
        logic shift_down;
        logic load;
    } chain_ctl_t;

endpackage

// File: design/dq_cell.sv
`timescale 1ns / 1ps

module dq_cell #(
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 9,
    parameter int INDEX      = 0
) (
    input  logic                         clk,
    input  dq_pkg::chain_ctl_t           ctl,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [VALUE_BITS-1:0] load_value,
    input  logic signed [VALUE_BITS-1:0] from_lower,
    input  logic signed [VALUE_BITS-1:0] from_upper,
    output logic signed [VALUE_BITS-1:0] data
);

    logic signed [VALUE_BITS-1:0] data_reg;
    logic signed [VALUE_BITS-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (ctl.shift_up)
        begin
            data_next = from_lower;
        end
        else if (ctl.shift_down)
        begin
            data_next = from_upper;
        end
        else if (ctl.load && (count == CNT_W'(INDEX)))
        begin
            data_next = load_value;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: design/dq_chain.sv
`timescale 1ns / 1ps

module dq_chain #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32,
    parameter int CNT_W      = 9
) (
    input  logic                         clk,
    input  dq_pkg::chain_ctl_t           ctl,
    input  logic [CNT_W-1:0]             count,
    input  logic signed [VALUE_BITS-1:0] value,
    output logic signed [VALUE_BITS-1:0] head
);

    logic signed [VALUE_BITS-1:0] cell_data [DEPTH];

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic signed [VALUE_BITS-1:0] lower;
        logic signed [VALUE_BITS-1:0] upper;

        if (i == 0)
        begin : g_first
            assign lower = value;
        end
        else
        begin : g_inner_lo
            assign lower = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign upper = cell_data[i];
        end
        else
        begin : g_inner_hi
            assign upper = cell_data[i+1];
        end

        dq_cell #(
            .VALUE_BITS(VALUE_BITS),
            .CNT_W     (CNT_W),
            .INDEX     (i)
        ) u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .count     (count),
            .load_value(value),
            .from_lower(lower),
            .from_upper(upper),
            .data      (cell_data[i])
        );
    end

    assign head = cell_data[0];

endmodule

// File: design/double_ended_queue.sv
`timescale 1ns / 1ps
// result: the strobe is registered and comes in the cycle after the transaction is taken
// throughput: one transaction per cycle, busy stays low; each request shifts one row
// of cells and, for a push, loads one cell of the other row, all in the same cycle
// reset: asynchronous, empties the deque and clears the strobe; cell data is not reset
// the receiver cannot stall, so each result is shown for exactly one cycle

module double_ended_queue #(
    parameter int DEPTH      = 256,
    parameter int VALUE_BITS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  dq_pkg::req_t     req,
    output logic             done,
    output dq_pkg::result_t  result
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             count_next;
    logic                         done_reg;
    dq_pkg::status_t              status_reg;
    dq_pkg::status_t              status_next;
    dq_pkg::chain_ctl_t           front_ctl;
    dq_pkg::chain_ctl_t           back_ctl;
    logic signed [VALUE_BITS-1:0] stored_value;
    logic signed [VALUE_BITS-1:0] front_head;
    logic signed [VALUE_BITS-1:0] back_head;
    logic                         accept;
    logic                         full;
    logic                         empty;

    assign busy         = 1'b0;
    assign accept       = start && !busy;
    assign full         = (count_reg == CNT_W'(DEPTH));
    assign empty        = (count_reg == '0);
    assign stored_value = VALUE_BITS'(req.value);

    always_comb
    begin
        count_next  = count_reg;
        status_next = dq_pkg::ST_DONE;
        front_ctl   = '0;
        back_ctl    = '0;
        if (accept)
        begin
            case (req.req_type)
                dq_pkg::REQ_PUSH_FRONT:
                begin
                    if (full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_ctl.shift_up = 1'b1;
                        back_ctl.load      = 1'b1;
                        count_next         = count_reg + 1'b1;
                    end
                end
                dq_pkg::REQ_PUSH_BACK:
                begin
                    if (full)
                    begin
                        status_next = dq_pkg::ST_FULL;
                    end
                    else
                    begin
                        front_ctl.load    = 1'b1;
                        back_ctl.shift_up = 1'b1;
                        count_next        = count_reg + 1'b1;
                    end
                end
                dq_pkg::REQ_POP_FRONT:
                begin
                    if (empty)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        front_ctl.shift_down = 1'b1;
                        count_next           = count_reg - 1'b1;
                    end
                end
                dq_pkg::REQ_POP_BACK:
                begin
                    if (empty)
                    begin
                        status_next = dq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        back_ctl.shift_down = 1'b1;
                        count_next          = count_reg - 1'b1;
                    end
                end
                default:
                begin
                    status_next = dq_pkg::ST_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            done_reg   <= 1'b0;
            status_reg <= dq_pkg::ST_DONE;
        end
        else
        begin
            count_reg  <= count_next;
            done_reg   <= accept;
            status_reg <= status_next;
        end
    end

    // front-ordered row: element 0 is the front
    dq_chain #(
        .DEPTH     (DEPTH),
        .VALUE_BITS(VALUE_BITS),
        .CNT_W     (CNT_W)
    ) u_front_chain (
        .clk  (clk),
        .ctl  (front_ctl),
        .count(count_reg),
        .value(stored_value),
        .head (front_head)
    );

    // back-ordered row: element 0 is the back
    dq_chain #(
        .DEPTH     (DEPTH),
        .VALUE_BITS(VALUE_BITS),
        .CNT_W     (CNT_W)
    ) u_back_chain (
        .clk  (clk),
        .ctl  (back_ctl),
        .count(count_reg),
        .value(stored_value),
        .head (back_head)
    );

    assign done                 = done_reg;
    assign result.front_value   = empty ? 32'sd0 : 32'(front_head);
    assign result.back_value    = empty ? 32'sd0 : 32'(back_head);
    assign result.element_count = 9'(count_reg);
    assign result.is_empty      = empty;
    assign result.status        = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("element count beyond depth");

    a_start_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> done)
        else $error("transaction without result strobe");

    a_reject_holds: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status != dq_pkg::ST_DONE) |-> $stable(count_reg))
        else $error("rejected request changed the count");

    a_full_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == dq_pkg::ST_FULL) |-> full)
        else $error("push dropped while not full");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        done && (result.status == dq_pkg::ST_EMPTY) |-> empty)
        else $error("pop ignored while not empty");

endmodule

// File: bench/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;

    localparam int DQ_DEPTH = 256;
    localparam int RANDOM_ITEMS = 1400;

    typedef struct packed {
        dq_pkg::req_t    stim;
        logic            typed;
        dq_pkg::result_t want;
    } stim_row_t;

    localparam dq_pkg::result_t POP_IGNORED =
        '{32'sd0, 32'sd0, 9'd0, 1'b1, dq_pkg::ST_EMPTY};
    localparam dq_pkg::result_t NOW_EMPTY =
        '{32'sd0, 32'sd0, 9'd0, 1'b1, dq_pkg::ST_DONE};

    localparam stim_row_t DIRECTED_ROWS [18] = '{
        '{'{dq_pkg::REQ_POP_FRONT,  32'sd0},           1'b1, POP_IGNORED},
        '{'{dq_pkg::REQ_POP_BACK,   32'shFFFFFFFF},    1'b1, POP_IGNORED},
        '{'{dq_pkg::REQ_PUSH_BACK,  32'sh7FFFFFFF},    1'b1,
            '{32'sh7FFFFFFF, 32'sh7FFFFFFF, 9'd1, 1'b0, dq_pkg::ST_DONE}},
        '{'{dq_pkg::REQ_PUSH_FRONT, 32'sh80000000},    1'b1,
            '{32'sh80000000, 32'sh7FFFFFFF, 9'd2, 1'b0, dq_pkg::ST_DONE}},
        '{'{dq_pkg::REQ_POP_BACK,   32'sd0},           1'b1,
            '{32'sh80000000, 32'sh80000000, 9'd1, 1'b0, dq_pkg::ST_DONE}},
        // last element popped leaves no stale back value
        '{'{dq_pkg::REQ_POP_FRONT,  32'sd0},           1'b1, NOW_EMPTY},
        '{'{dq_pkg::REQ_POP_BACK,   32'sd0},           1'b1, POP_IGNORED},
        // head wraps below slot zero
        '{'{dq_pkg::REQ_PUSH_FRONT, 32'shFFFFFFFF},    1'b1,
            '{32'shFFFFFFFF, 32'shFFFFFFFF, 9'd1, 1'b0, dq_pkg::ST_DONE}},
        '{'{dq_pkg::REQ_PUSH_FRONT, 32'sd0},           1'b0, '0},
        '{'{dq_pkg::REQ_PUSH_BACK,  32'sd1},           1'b0, '0},
        '{'{dq_pkg::REQ_PUSH_BACK,  32'sh55555555},    1'b0, '0},
        '{'{dq_pkg::REQ_PUSH_FRONT, 32'shAAAAAAAA},    1'b0, '0},
        '{'{dq_pkg::REQ_POP_FRONT,  32'sh12345678},    1'b0, '0},
        '{'{dq_pkg::REQ_POP_BACK,   32'sd0},           1'b0, '0},
        '{'{dq_pkg::REQ_POP_FRONT,  32'sd0},           1'b0, '0},
        '{'{dq_pkg::REQ_POP_BACK,   32'sd0},           1'b0, '0},
        '{'{dq_pkg::REQ_POP_FRONT,  32'shFFFFFFFF},    1'b0, '0},
        '{'{dq_pkg::REQ_POP_BACK,   32'sd0},           1'b1, POP_IGNORED}
    };

    logic            clk;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    dq_pkg::req_t    req = '0;
    logic            done;
    dq_pkg::result_t result;

    logic signed [31:0] cells [DQ_DEPTH];
    logic [7:0]         front_idx = '0;
    logic [7:0]         back_idx = '0;
    logic [8:0]         held = '0;

    // expected results in order, written by the sender and read by the checker
    dq_pkg::result_t expect_ring [16];
    int              expect_wr = 0;
    int              expect_rd = 0;
    int              idle_pct;
    int              fail_count = 0;

    double_ended_queue dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .req    (req),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #200000;
        $display("FAILURE");
        $finish;
    end

    // advances the deque state by one request and returns the reported result
    function automatic dq_pkg::result_t deque_apply(dq_pkg::req_t r);
        dq_pkg::result_t res;
        logic [7:0]      last_idx;
        res = '0;
        res.status = dq_pkg::ST_DONE;
        case (r.req_type)
            dq_pkg::REQ_PUSH_FRONT, dq_pkg::REQ_PUSH_BACK:
            begin
                if (held == DQ_DEPTH)
                    res.status = dq_pkg::ST_FULL;
                else if (r.req_type == dq_pkg::REQ_PUSH_FRONT)
                begin
                    front_idx = front_idx - 8'd1;
                    cells[front_idx] = r.value;
                    held = held + 9'd1;
                end
                else
                begin
                    cells[back_idx] = r.value;
                    back_idx = back_idx + 8'd1;
                    held = held + 9'd1;
                end
            end
            default:
            begin
                if (held == 0)
                    res.status = dq_pkg::ST_EMPTY;
                else if (r.req_type == dq_pkg::REQ_POP_FRONT)
                begin
                    front_idx = front_idx + 8'd1;
                    held = held - 9'd1;
                end
                else
                begin
                    back_idx = back_idx - 8'd1;
                    held = held - 9'd1;
                end
            end
        endcase
        last_idx = back_idx - 8'd1;
        if (held != 0)
        begin
            res.front_value = cells[front_idx];
            res.back_value = cells[last_idx];
        end
        res.element_count = held;
        res.is_empty = (held == 0);
        return res;
    endfunction

    task automatic send(dq_pkg::req_t r, logic typed, dq_pkg::result_t want);
        dq_pkg::result_t predicted;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req <= r;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predicted = deque_apply(r);
        expect_ring[expect_wr[3:0]] = typed ? want : predicted;
        expect_wr++;
    endtask

    task automatic compare_field(string name, longint want, longint got);
        if (want != got)
        begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : check_results
        dq_pkg::result_t want;
        if (rst_n && done)
        begin
            if (expect_wr == expect_rd)
            begin
                $display("%0t ns: unexpected transaction result %p", $time, result);
                fail_count++;
            end
            else
            begin
                want = expect_ring[expect_rd[3:0]];
                expect_rd++;
                compare_field("front_value", want.front_value, result.front_value);
                compare_field("back_value", want.back_value, result.back_value);
                compare_field("element_count", want.element_count, result.element_count);
                compare_field("is_empty", want.is_empty, result.is_empty);
                compare_field("status", want.status, result.status);
            end
        end
    end

    initial
    begin : stimulus
        dq_pkg::req_t r;
        int           push_pct;
        int           seg_left;
        int           seg_count;
        foreach (cells[i])
            cells[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 29;
        foreach (DIRECTED_ROWS[i])
            send(DIRECTED_ROWS[i].stim, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);

        // fill to full, drain to empty, then random mixes of both
        seg_left = 0;
        seg_count = 0;
        push_pct = 50;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (n < RANDOM_ITEMS / 3)
                idle_pct = 29;
            else if (n < 2 * RANDOM_ITEMS / 3)
                idle_pct = 54;
            else
                idle_pct = 0;
            if (seg_left == 0)
            begin
                if (seg_count == 0)
                begin
                    push_pct = 95;
                    seg_left = 320;
                end
                else if (seg_count == 1)
                begin
                    push_pct = 5;
                    seg_left = 320;
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0: push_pct = 95;
                        1: push_pct = 5;
                        default: push_pct = 50;
                    endcase
                    seg_left = $urandom_range(20, 300);
                end
                seg_count++;
            end
            seg_left--;
            if ($urandom_range(0, 99) < push_pct)
                r.req_type = $urandom_range(0, 1) ? dq_pkg::REQ_PUSH_BACK
                                                  : dq_pkg::REQ_PUSH_FRONT;
            else
                r.req_type = $urandom_range(0, 1) ? dq_pkg::REQ_POP_BACK
                                                  : dq_pkg::REQ_POP_FRONT;
            r.value = $urandom;
            send(r, 1'b0, '0);
        end
        start <= 1'b0;

        while (expect_wr != expect_rd)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
